@@ design/chb_pkg.sv @@
`default_nettype none

package chb_pkg;

  // Field and port widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CFG_IW  = 1;
  localparam int unsigned HALF_W  = WORD_W / 2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_MAP_LENGTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_BINARY_MODE = 1'b1;

  // Register reset values
  localparam logic [CFG_DW-1:0] MAP_LENGTH_RST = 32'h0001_0000;

  // Hash constants
  localparam logic [HASH_W-1:0] SEED_CONST = 32'ha5b3_5705;
  localparam logic [WORD_W-1:0] MIX_C1     = 64'h87c3_7b91_1142_53d5;
  localparam logic [WORD_W-1:0] MIX_C2     = 64'h4cf5_ad43_2745_937f;
  localparam logic [WORD_W-1:0] MIX_ADD    = 64'h0000_0000_52dc_e729;
  localparam logic [WORD_W-1:0] FMIX_C1    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [WORD_W-1:0] FMIX_C2    = 64'hc4ce_b9fe_1a85_ec53;
  localparam int unsigned       ROT_K      = 31;
  localparam int unsigned       ROT_H      = 27;
  localparam int unsigned       FMIX_SHIFT = 33;

  // Main sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MIX,
    S_FIN1,
    S_FIN2,
    S_DONE
  } state_t;

  // Steps of the shared multiplier
  typedef enum logic [2:0] {
    MS_IDLE,
    MS_LL,
    MS_LH,
    MS_HL,
    MS_SUM
  } mul_step_t;

  // Multiplier status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

`default_nettype wire

@@ design/chb_if.sv @@
`default_nettype none

// Input channel: one coverage word per handshake
interface chb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] count_word;
  logic        word_present;
  logic        last_word;

  modport source (output valid, output count_word, output word_present,
                  output last_word, input ready);
  modport sink   (input valid, input count_word, input word_present,
                  input last_word, output ready);
endinterface

// Result channel: one finished hash per handshake
interface chb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

@@ design/chb_binner.sv @@
`default_nettype none

module chb_binner (
  input  wire logic [chb_pkg::WORD_W-1:0] raw_word,
  input  wire logic                       binary_mode,
  output logic      [chb_pkg::WORD_W-1:0] binned_word
);
  import chb_pkg::*;

  localparam int unsigned NBYTES = WORD_W / 8;

  // Count class of one byte
  function automatic logic [7:0] bin_byte(input logic [7:0] c, input logic bmode);
    logic [7:0] r;
    if (bmode) begin
      r = (c != 8'd0) ? 8'd1 : 8'd0;
    end else begin
      case (c) inside
        8'd0:            r = 8'd0;
        8'd1:            r = 8'd1;
        8'd2:            r = 8'd2;
        8'd3:            r = 8'd4;
        [8'd4:8'd7]:     r = 8'd8;
        [8'd8:8'd15]:    r = 8'd16;
        [8'd16:8'd31]:   r = 8'd32;
        [8'd32:8'd127]:  r = 8'd64;
        default:         r = 8'd128;
      endcase
    end
    return r;
  endfunction

  // Eight independent byte lanes
  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      binned_word[8*i +: 8] = bin_byte(raw_word[8*i +: 8], binary_mode);
    end
  end

endmodule

`default_nettype wire

@@ design/chb_mul64.sv @@
`default_nettype none

// Low 64 bits of a 64x64 product, from three 32x32 partial products
// on one multiplier: lo*lo, lo*hi, hi*lo, then a final sum.
module chb_mul64 (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [chb_pkg::WORD_W-1:0] op_a,
  input  wire logic [chb_pkg::WORD_W-1:0] op_b,
  output chb_pkg::mul_status_t            status,
  output logic      [chb_pkg::WORD_W-1:0] product
);
  import chb_pkg::*;

  mul_step_t           step_r, step_nxt;
  logic [WORD_W-1:0]   a_r, b_r;
  logic [WORD_W-1:0]   pp_r;
  logic [WORD_W-1:0]   acc_r;
  logic [HALF_W-1:0]   m_x, m_y;
  logic [WORD_W-1:0]   pp_hi;

  // Step sequence
  always_comb begin
    step_nxt = step_r;
    case (step_r)
      MS_IDLE: if (start) step_nxt = MS_LL;
      MS_LL:   step_nxt = MS_LH;
      MS_LH:   step_nxt = MS_HL;
      MS_HL:   step_nxt = MS_SUM;
      MS_SUM:  step_nxt = MS_IDLE;
      default: step_nxt = MS_IDLE;
    endcase
  end

  // Operand select per step
  always_comb begin
    m_x = '0;
    m_y = '0;
    case (step_r)
      MS_LL: begin
        m_x = a_r[HALF_W-1:0];
        m_y = b_r[HALF_W-1:0];
      end
      MS_LH: begin
        m_x = a_r[HALF_W-1:0];
        m_y = b_r[WORD_W-1:HALF_W];
      end
      MS_HL: begin
        m_x = a_r[WORD_W-1:HALF_W];
        m_y = b_r[HALF_W-1:0];
      end
      default: begin
        m_x = '0;
        m_y = '0;
      end
    endcase
  end

  // Cross terms only contribute their low half, shifted up
  assign pp_hi = {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};

  // Status and result
  always_comb begin
    status.busy = (step_r != MS_IDLE);
    status.done = (step_r == MS_SUM);
    product     = acc_r + pp_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= MS_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Operand latch, partial product and running sum
  always_ff @(posedge clk) begin
    if (step_r == MS_IDLE && start) begin
      a_r <= op_a;
      b_r <= op_b;
    end
    pp_r <= m_x * m_y;
    case (step_r)
      MS_LH:   acc_r <= pp_r;
      MS_HL:   acc_r <= acc_r + pp_hi;
      default: acc_r <= acc_r;
    endcase
  end

endmodule

`default_nettype wire

@@ design/coverage_bin_and_hash.sv @@
`default_nettype none

// Channel  Dir  Word                                   Handshake
// in_ch    in   count_word, word_present, last_word    valid/ready
// out_ch   out  hash_value                             valid/ready
// cfg_*    in   index 0 map_length, 1 binary_mode      write enable only
//
// A present word keeps the block busy after acceptance for two 64-bit
// multiplies on the shared 32x32 multiplier (three partial products and a
// sum per product, each after a start step) and one mix step.
// A finishing word adds two more products and the output load.
// An item with neither flag is taken and dropped; the sequencer stays idle.
// Synchronous active-low reset sets the sequencer, flags and config registers.
// A result waits in the output register; the next word is taken meanwhile,
// and only a second result stalls until the first is taken.
module coverage_bin_and_hash (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [chb_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [chb_pkg::CFG_DW-1:0] cfg_wdata,
  chb_in_if.sink                          in_ch,
  chb_out_if.source                       out_ch
);
  import chb_pkg::*;

  state_t              state_r, state_nxt;
  logic [CFG_DW-1:0]   map_length_r;
  logic                binary_mode_r;
  logic                mid_map_r;
  logic                last_r;
  logic [WORD_W-1:0]   k_r;
  logic [WORD_W-1:0]   acc_r;
  logic [WORD_W-1:0]   f_r;
  logic                out_valid_r;
  logic [HASH_W-1:0]   out_hash_r;

  logic [WORD_W-1:0]   binned;
  logic [WORD_W-1:0]   seed;
  logic [WORD_W-1:0]   mix_h;
  logic [WORD_W-1:0]   acc_fold;
  logic [WORD_W-1:0]   f_fold;
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [WORD_W-1:0]   mul_p;
  logic                mul_start;
  mul_status_t         mul_st;
  logic                in_take;
  logic                out_free;
  logic                out_load;

  chb_binner u_binner (
    .raw_word    (in_ch.count_word),
    .binary_mode (binary_mode_r),
    .binned_word (binned)
  );

  chb_mul64 u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .status  (mul_st),
    .product (mul_p)
  );

  // Datapath helpers
  assign seed     = {{(WORD_W-CFG_DW){1'b0}}, SEED_CONST ^ map_length_r};
  assign mix_h    = ((acc_r ^ k_r) << ROT_H) | ((acc_r ^ k_r) >> (WORD_W - ROT_H));
  assign acc_fold = acc_r ^ (acc_r >> FMIX_SHIFT);
  assign f_fold   = f_r ^ (f_r >> FMIX_SHIFT);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_ch.word_present)   state_nxt = S_MUL1;
          else if (in_ch.last_word) state_nxt = S_FIN1;
        end
      end
      S_MUL1:  if (mul_st.done) state_nxt = S_MUL2;
      S_MUL2:  if (mul_st.done) state_nxt = S_MIX;
      S_MIX:   state_nxt = last_r ? S_FIN1 : S_IDLE;
      S_FIN1:  if (mul_st.done) state_nxt = S_FIN2;
      S_FIN2:  if (mul_st.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    mul_start   = 1'b0;
    mul_a       = k_r;
    mul_b       = MIX_C1;
    out_load    = 1'b0;
    case (state_r)
      S_MUL1: begin
        mul_start = !mul_st.busy;
        mul_a     = k_r;
        mul_b     = MIX_C1;
      end
      S_MUL2: begin
        mul_start = !mul_st.busy;
        mul_a     = k_r;
        mul_b     = MIX_C2;
      end
      S_FIN1: begin
        mul_start = !mul_st.busy;
        mul_a     = acc_fold;
        mul_b     = FMIX_C1;
      end
      S_FIN2: begin
        mul_start = !mul_st.busy;
        mul_a     = f_fold;
        mul_b     = FMIX_C2;
      end
      S_DONE:  out_load = out_free;
      default: begin
        mul_start = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      map_length_r  <= MAP_LENGTH_RST;
      binary_mode_r <= 1'b0;
      mid_map_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAP_LENGTH:  map_length_r  <= cfg_wdata;
          REG_BINARY_MODE: binary_mode_r <= cfg_wdata[0];
          default:         map_length_r  <= map_length_r;
        endcase
      end
      if (in_take && (in_ch.word_present || in_ch.last_word)) begin
        mid_map_r <= 1'b1;
      end else if (out_load) begin
        mid_map_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hash datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      k_r    <= binned;
      last_r <= in_ch.last_word;
      if (!mid_map_r) acc_r <= seed;
    end
    case (state_r)
      S_MUL1: if (mul_st.done) k_r <= (mul_p << ROT_K) | (mul_p >> (WORD_W - ROT_K));
      S_MUL2: if (mul_st.done) k_r <= mul_p;
      S_MIX:  acc_r <= (mix_h << 2) + mix_h + MIX_ADD;
      S_FIN1: if (mul_st.done) f_r <= mul_p;
      S_FIN2: if (mul_st.done) f_r <= mul_p;
      default: f_r <= f_r;
    endcase
    if (out_load) out_hash_r <= f_fold[HASH_W-1:0];
  end

`ifndef SYNTHESIS
  // No word is taken while a product is in flight
  a_ready_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !mul_st.busy)
    else $error("input ready while multiplier busy");

  // A new result only comes from the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside finish");

  // An empty item leaves the sequencer idle
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !in_ch.word_present && !in_ch.last_word) |=> state_r == S_IDLE)
    else $error("empty item started work");
`endif

endmodule

`default_nettype wire
